>>> design/sbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_pkg: shared definitions for the stable bin sorter
// Field widths, default sizes, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package sbs_pkg;

    // Field widths of a record and of a result.
    localparam int KEY_W     = 8;
    localparam int PAYLOAD_W = 16;
    localparam int DROP_W    = 7;

    // The drop counter saturates here.
    localparam logic [DROP_W-1:0] DROP_MAX = 7'd127;

    // Default store depth.
    localparam int MAX_RECORDS_DEF = 64;

    // Number of bins: a record is kept only if key - range_low is below this.
    localparam int NUM_BINS = 32;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } sbs_state_t;

endpackage

>>> design/stable_bin_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_bin_sort: stable sort of a batch of keyed records
// Loads records one per request, then emits the kept ones by ascending key.
// ----------------------------------------------------------------------------
// Usage:
//   A request (key, payload, batch_last) is taken at a rising edge where start
//   is high and busy is low. Records with range_low <= key <= range_high,
//   key - range_low below the bin count and room left in the store are kept;
//   the others are dropped and counted (the count saturates at 127).
//   Busy stays low while records load, so requests can follow back to back.
//   On the request with batch_last set, busy rises and the kept records come
//   out on the result ports, one per cycle of result_valid, in ascending key
//   order and arrival order within equal keys; result_last marks the final
//   one. A batch that keeps nothing gives a single result with item_valid low
//   on the next cycle, and busy never rises.
//   Emission runs one shared compare unit over the record memory, one entry
//   per cycle: one pass to find the smallest key and one pass per distinct
//   key that emits it and finds the next one.
//   The receiver cannot stall; results are strobes. Reset clears the
//   batch, sets range_low to 0 and range_high to 31. Registers are written
//   through cfg_write, cfg_index and cfg_data; the user must do so only
//   at idle time, since the block itself does not enforce it.
// ----------------------------------------------------------------------------
module stable_bin_sort
    import sbs_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Request channel
    input  logic                  start,
    output logic                  busy,
    input  logic [KEY_W-1:0]      key,
    input  logic [PAYLOAD_W-1:0]  payload,
    input  logic                  batch_last,
    // Result channel
    output logic                  result_valid,
    output logic [KEY_W-1:0]      sorted_key,
    output logic [PAYLOAD_W-1:0]  sorted_payload,
    output logic                  item_valid,
    output logic [DROP_W-1:0]     dropped_count,
    output logic                  result_last,
    // Configuration port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [KEY_W-1:0]      cfg_data
);

    localparam int IDX_W = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int REC_W = KEY_W + PAYLOAD_W;

    sbs_state_t state_reg, state_next;

    logic [KEY_W-1:0]     low_reg, high_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DROP_W-1:0]    drop_reg, drop_next;
    logic [CNT_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic                 rd_vld_reg, rd_last_reg;
    logic [KEY_W-1:0]     cur_reg, cur_next;
    logic                 cur_vld_reg, cur_vld_next;
    logic [KEY_W-1:0]     nxt_reg, nxt_next;
    logic                 nxt_vld_reg, nxt_vld_next;
    logic [KEY_W-1:0]     pend_key_reg, pend_key_next;
    logic [PAYLOAD_W-1:0] pend_pay_reg, pend_pay_next;
    logic                 pend_vld_reg, pend_vld_next;

    logic                 res_valid_reg, res_valid_next;
    logic [KEY_W-1:0]     res_key_reg, res_key_next;
    logic [PAYLOAD_W-1:0] res_pay_reg, res_pay_next;
    logic                 res_item_reg, res_item_next;
    logic [DROP_W-1:0]    res_drop_reg, res_drop_next;
    logic                 res_last_reg, res_last_next;

    logic [REC_W-1:0]     mem [MAX_RECORDS];
    logic [REC_W-1:0]     mem_q;

    logic                 accept;
    logic                 keep;
    logic [KEY_W-1:0]     offset;
    logic [CNT_W-1:0]     cnt_load;
    logic [DROP_W-1:0]    drop_load;
    logic                 issue;
    logic [KEY_W-1:0]     scan_key;
    logic [PAYLOAD_W-1:0] scan_pay;
    logic                 match;
    logic                 cand;
    logic [KEY_W-1:0]     nxt_upd;
    logic                 nxt_vld_upd;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Keep test for an incoming record.
    assign offset = key - low_reg;
    assign keep   = (key >= low_reg) && (key <= high_reg) &&
                    ({1'b0, offset} < 9'(NUM_BINS)) &&
                    (cnt_reg < CNT_W'(MAX_RECORDS));

    assign cnt_load  = keep ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign drop_load = (!keep && drop_reg != DROP_MAX) ? drop_reg + DROP_W'(1) : drop_reg;

    // Read issue during a scan pass.
    assign issue = (state_reg == ST_SCAN) && (rd_ptr_reg < cnt_reg);

    // Shared compare unit on the record read back from memory.
    assign scan_key    = mem_q[REC_W-1:PAYLOAD_W];
    assign scan_pay    = mem_q[PAYLOAD_W-1:0];
    assign match       = cur_vld_reg && (scan_key == cur_reg);
    assign cand        = (!cur_vld_reg || scan_key > cur_reg) &&
                         (!nxt_vld_reg || scan_key < nxt_reg);
    assign nxt_upd     = cand ? scan_key : nxt_reg;
    assign nxt_vld_upd = cand || nxt_vld_reg;

    // Record memory: written on load, read one entry per scan cycle.
    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            mem[cnt_reg[IDX_W-1:0]] <= {key, payload};
        end
        mem_q <= mem[rd_ptr_reg[IDX_W-1:0]];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= 8'd31;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RANGE_LOW:  low_reg  <= cfg_data;
                REG_RANGE_HIGH: high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            drop_reg      <= '0;
            rd_ptr_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            cur_vld_reg   <= 1'b0;
            nxt_vld_reg   <= 1'b0;
            pend_vld_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            drop_reg      <= drop_next;
            rd_ptr_reg    <= rd_ptr_next;
            rd_vld_reg    <= issue;
            rd_last_reg   <= (rd_ptr_reg == cnt_reg - CNT_W'(1));
            cur_vld_reg   <= cur_vld_next;
            nxt_vld_reg   <= nxt_vld_next;
            pend_vld_reg  <= pend_vld_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_next;
        pend_key_reg <= pend_key_next;
        pend_pay_reg <= pend_pay_next;
        res_key_reg  <= res_key_next;
        res_pay_reg  <= res_pay_next;
        res_item_reg <= res_item_next;
        res_drop_reg <= res_drop_next;
        res_last_reg <= res_last_next;
    end

    // Sequencer: load, empty-batch result, scan passes and final flush.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        drop_next      = drop_reg;
        rd_ptr_next    = rd_ptr_reg;
        cur_next       = cur_reg;
        cur_vld_next   = cur_vld_reg;
        nxt_next       = nxt_reg;
        nxt_vld_next   = nxt_vld_reg;
        pend_key_next  = pend_key_reg;
        pend_pay_next  = pend_pay_reg;
        pend_vld_next  = pend_vld_reg;
        res_valid_next = 1'b0;
        res_key_next   = res_key_reg;
        res_pay_next   = res_pay_reg;
        res_item_next  = res_item_reg;
        res_drop_next  = res_drop_reg;
        res_last_next  = res_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next  = cnt_load;
                    drop_next = drop_load;
                    if (batch_last)
                    begin
                        if (cnt_load == '0)
                        begin
                            // Nothing kept: a single empty result.
                            res_valid_next = 1'b1;
                            res_key_next   = '0;
                            res_pay_next   = '0;
                            res_item_next  = 1'b0;
                            res_drop_next  = drop_load;
                            res_last_next  = 1'b1;
                            cnt_next       = '0;
                            drop_next      = '0;
                        end
                        else
                        begin
                            state_next    = ST_SCAN;
                            rd_ptr_next   = '0;
                            cur_vld_next  = 1'b0;
                            nxt_vld_next  = 1'b0;
                            pend_vld_next = 1'b0;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    // A record of the current key: release the held one.
                    if (match)
                    begin
                        if (pend_vld_reg)
                        begin
                            res_valid_next = 1'b1;
                            res_key_next   = pend_key_reg;
                            res_pay_next   = pend_pay_reg;
                            res_item_next  = 1'b1;
                            res_drop_next  = drop_reg;
                            res_last_next  = 1'b0;
                        end
                        pend_key_next = scan_key;
                        pend_pay_next = scan_pay;
                        pend_vld_next = 1'b1;
                    end
                    if (rd_last_reg)
                    begin
                        // End of pass: move to the next key or finish.
                        if (nxt_vld_upd)
                        begin
                            cur_next     = nxt_upd;
                            cur_vld_next = 1'b1;
                            nxt_vld_next = 1'b0;
                            rd_ptr_next  = '0;
                        end
                        else
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    else
                    begin
                        nxt_next     = nxt_upd;
                        nxt_vld_next = nxt_vld_upd;
                    end
                end
            end

            ST_FLUSH:
            begin
                res_valid_next = 1'b1;
                res_key_next   = pend_key_reg;
                res_pay_next   = pend_pay_reg;
                res_item_next  = 1'b1;
                res_drop_next  = drop_reg;
                res_last_next  = 1'b1;
                pend_vld_next  = 1'b0;
                cnt_next       = '0;
                drop_next      = '0;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid   = res_valid_reg;
    assign sorted_key     = res_key_reg;
    assign sorted_payload = res_pay_reg;
    assign item_valid     = res_item_reg;
    assign dropped_count  = res_drop_reg;
    assign result_last    = res_last_reg;

`ifndef NO_ASSERTIONS
    // A scan only runs over a non-empty store.
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg != '0))
        else $error("scan running with an empty store");

    // Read data only arrives during a scan.
    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == ST_SCAN))
        else $error("memory read data outside a scan");

    // The flush always emits a held record as the final result.
    a_flush_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> pend_vld_reg ##1 (result_valid && result_last))
        else $error("flush without a held record");

    // An empty result is always the final result.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !item_valid) |-> result_last)
        else $error("empty result not marked last");

    // The store never holds more than its depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count beyond store depth");
`endif

endmodule
